FILE: rtl/core/grid_wavefront_shortest_path_defines.svh
// assertion macros for the wavefront router
`ifndef GRID_WAVEFRONT_SHORTEST_PATH_DEFINES_SVH
`define GRID_WAVEFRONT_SHORTEST_PATH_DEFINES_SVH
`ifndef SYNTH
`define GWSP_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GWSP_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GWSP_ASSERT(label, clk, rst, prop, msg)
`define GWSP_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

FILE: rtl/core/gwsp_pkg.sv
`default_nettype none
package gwsp_pkg;

  localparam int GRID_SIDE  = 64;
  localparam int COORD_W    = $clog2(GRID_SIDE);
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int CELLS      = 1 << ADDR_W;
  localparam int COORD_IN_W = 16;
  localparam int SPAN_W     = COORD_IN_W + 1;
  localparam int LABEL_W    = 13;
  localparam int LEN_W      = 12;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [LEN_W-1:0]   len_t;

  localparam label_t LABEL_FREE  = '0;
  localparam label_t LABEL_START = LABEL_W'(1);
  localparam label_t WAVE_FIRST  = LABEL_W'(2);
  localparam label_t WAVE_LIMIT  = LABEL_W'(13'h1FFD);
  localparam label_t MARK_BLOCK  = LABEL_W'(13'h1FFE);
  localparam label_t MARK_GOAL   = LABEL_W'(13'h1FFF);
  localparam len_t   LEN_MAX     = LEN_W'(4095);

  // largest max-min span whose padded box still fits the grid
  localparam logic [SPAN_W-1:0] SPAN_LIMIT = SPAN_W'(GRID_SIDE - 3);

  typedef struct packed {
    logic   too_large;
    coord_t x_last;
    coord_t y_last;
    coord_t sx;
    coord_t sy;
    coord_t gx;
    coord_t gy;
    coord_t bx;
    coord_t by;
  } box_t;

  typedef struct packed {
    len_t path_length;
    logic reachable;
    logic too_large;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/gwsp_box.sv
`default_nettype none
module gwsp_box import gwsp_pkg::*; (
  input  logic signed [COORD_IN_W-1:0] start_x,
  input  logic signed [COORD_IN_W-1:0] start_y,
  input  logic signed [COORD_IN_W-1:0] goal_x,
  input  logic signed [COORD_IN_W-1:0] goal_y,
  input  logic signed [COORD_IN_W-1:0] block_x,
  input  logic signed [COORD_IN_W-1:0] block_y,
  output box_t                         box
);

  logic signed [SPAN_W-1:0] sx, sy, gx, gy, bx, by;
  logic signed [SPAN_W-1:0] min_x, min_y, max_x, max_y;
  logic        [SPAN_W-1:0] span_x, span_y;
  logic signed [SPAN_W-1:0] rel_sx, rel_sy, rel_gx, rel_gy, rel_bx, rel_by;

  always_comb begin
    sx = SPAN_W'(start_x);
    sy = SPAN_W'(start_y);
    gx = SPAN_W'(goal_x);
    gy = SPAN_W'(goal_y);
    bx = SPAN_W'(block_x);
    by = SPAN_W'(block_y);

    min_x = sx;
    if (gx < min_x) min_x = gx;
    if (bx < min_x) min_x = bx;
    max_x = sx;
    if (gx > max_x) max_x = gx;
    if (bx > max_x) max_x = bx;
    min_y = sy;
    if (gy < min_y) min_y = gy;
    if (by < min_y) min_y = by;
    max_y = sy;
    if (gy > max_y) max_y = gy;
    if (by > max_y) max_y = by;

    // never negative, so it reads as unsigned
    span_x = SPAN_W'(max_x - min_x);
    span_y = SPAN_W'(max_y - min_y);

    // coordinates relative to the padded box origin (min - 1)
    rel_sx = sx - min_x + SPAN_W'(1);
    rel_sy = sy - min_y + SPAN_W'(1);
    rel_gx = gx - min_x + SPAN_W'(1);
    rel_gy = gy - min_y + SPAN_W'(1);
    rel_bx = bx - min_x + SPAN_W'(1);
    rel_by = by - min_y + SPAN_W'(1);

    box.too_large = (span_x > SPAN_LIMIT) || (span_y > SPAN_LIMIT);
    box.x_last    = COORD_W'(span_x + SPAN_W'(2));
    box.y_last    = COORD_W'(span_y + SPAN_W'(2));
    box.sx        = COORD_W'(rel_sx);
    box.sy        = COORD_W'(rel_sy);
    box.gx        = COORD_W'(rel_gx);
    box.gy        = COORD_W'(rel_gy);
    box.bx        = COORD_W'(rel_bx);
    box.by        = COORD_W'(rel_by);
  end

endmodule
`default_nettype wire

FILE: rtl/core/gwsp_engine.sv
`default_nettype none
`include "grid_wavefront_shortest_path_defines.svh"
module gwsp_engine import gwsp_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  box_t    box_in,
  output logic    ready,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLEAR, ST_MARK_START, ST_MARK_BLOCK, ST_MARK_GOAL,
    ST_SCAN, ST_NB_RD, ST_NB_CHK, ST_WAVE_END, ST_DONE
  } state_t;

  typedef enum logic [1:0] {DIR_LEFT, DIR_UP, DIR_RIGHT, DIR_DOWN} dir_t;

  state_t state;
  box_t   box;
  addr_t  clr_addr;
  label_t wave;
  logic   grew;
  coord_t cx, cy;
  logic   cur_done;
  logic   pend;
  coord_t px, py;
  coord_t hx, hy;
  coord_t nx, ny;
  dir_t   dir;

  label_t labels [CELLS];
  label_t rdata;

  label_t prev;
  label_t cmp_ref;
  logic   cmp_eq;
  logic   is_free;
  logic   hit;
  logic   nb_ok;
  coord_t nbx, nby;
  addr_t  raddr;
  logic   we;
  addr_t  waddr;
  label_t wdata;
  label_t len_full;

  // single label comparator, shared between the scan and the neighbour check
  always_comb begin
    prev     = wave - LABEL_START;
    cmp_ref  = (state == ST_NB_CHK) ? MARK_GOAL : prev;
    cmp_eq   = (rdata == cmp_ref);
    is_free  = (rdata == LABEL_FREE);
    hit      = (state == ST_SCAN) && pend && cmp_eq;
    len_full = wave - LABEL_START;
  end

  // neighbour step: left, up, right, down, clipped to the box
  always_comb begin
    nbx   = hx;
    nby   = hy;
    nb_ok = 1'b0;
    case (dir)
      DIR_LEFT: begin
        nbx   = hx - COORD_W'(1);
        nb_ok = (hx != '0);
      end
      DIR_UP: begin
        nby   = hy - COORD_W'(1);
        nb_ok = (hy != '0);
      end
      DIR_RIGHT: begin
        nbx   = hx + COORD_W'(1);
        nb_ok = (hx != box.x_last);
      end
      DIR_DOWN: begin
        nby   = hy + COORD_W'(1);
        nb_ok = (hy != box.y_last);
      end
      default: begin
        nb_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    raddr = (state == ST_NB_RD) ? {nby, nbx} : {cy, cx};
    we    = 1'b0;
    waddr = clr_addr;
    wdata = LABEL_FREE;
    case (state)
      ST_CLEAR: begin
        we = 1'b1;
      end
      ST_MARK_START: begin
        we    = 1'b1;
        waddr = {box.sy, box.sx};
        wdata = LABEL_START;
      end
      ST_MARK_BLOCK: begin
        we    = 1'b1;
        waddr = {box.by, box.bx};
        wdata = MARK_BLOCK;
      end
      ST_MARK_GOAL: begin
        we    = 1'b1;
        waddr = {box.gy, box.gx};
        wdata = MARK_GOAL;
      end
      ST_NB_CHK: begin
        we    = !cmp_eq && is_free;
        waddr = {ny, nx};
        wdata = wave;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      labels[waddr] <= wdata;
    end
    rdata <= labels[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pend     <= 1'b0;
      cur_done <= 1'b0;
      grew     <= 1'b0;
      dir      <= DIR_LEFT;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            box             <= box_in;
            res.too_large   <= box_in.too_large;
            res.reachable   <= 1'b0;
            res.path_length <= '0;
            clr_addr        <= '0;
            state           <= box_in.too_large ? ST_DONE : ST_CLEAR;
          end
        end
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (&clr_addr) begin
            state <= ST_MARK_START;
          end
        end
        ST_MARK_START: begin
          state <= ST_MARK_BLOCK;
        end
        ST_MARK_BLOCK: begin
          state <= ST_MARK_GOAL;
        end
        ST_MARK_GOAL: begin
          wave     <= WAVE_FIRST;
          grew     <= 1'b0;
          cx       <= '0;
          cy       <= '0;
          cur_done <= 1'b0;
          pend     <= 1'b0;
          state    <= ST_SCAN;
        end
        ST_SCAN: begin
          if (hit) begin
            // cursor already points past the hit cell, resume there
            hx    <= px;
            hy    <= py;
            pend  <= 1'b0;
            dir   <= DIR_LEFT;
            state <= ST_NB_RD;
          end else if (cur_done) begin
            pend <= 1'b0;
            if (!pend) begin
              state <= ST_WAVE_END;
            end
          end else begin
            pend <= 1'b1;
            px   <= cx;
            py   <= cy;
            if (cx == box.x_last) begin
              cx <= '0;
              if (cy == box.y_last) begin
                cur_done <= 1'b1;
              end else begin
                cy <= cy + COORD_W'(1);
              end
            end else begin
              cx <= cx + COORD_W'(1);
            end
          end
        end
        ST_NB_RD: begin
          if (nb_ok) begin
            nx    <= nbx;
            ny    <= nby;
            state <= ST_NB_CHK;
          end else if (dir == DIR_DOWN) begin
            state <= ST_SCAN;
          end else begin
            dir <= dir_t'(2'(dir + 2'd1));
          end
        end
        ST_NB_CHK: begin
          if (cmp_eq) begin
            res.reachable   <= 1'b1;
            res.path_length <= (len_full > LABEL_W'(LEN_MAX)) ? LEN_MAX
                                                               : LEN_W'(len_full);
            state           <= ST_DONE;
          end else begin
            if (is_free) begin
              grew <= 1'b1;
            end
            if (dir == DIR_DOWN) begin
              state <= ST_SCAN;
            end else begin
              dir   <= dir_t'(2'(dir + 2'd1));
              state <= ST_NB_RD;
            end
          end
        end
        ST_WAVE_END: begin
          if (!grew || (wave >= WAVE_LIMIT)) begin
            state <= ST_DONE;
          end else begin
            wave     <= wave + LABEL_START;
            grew     <= 1'b0;
            cx       <= '0;
            cy       <= '0;
            cur_done <= 1'b0;
            pend     <= 1'b0;
            state    <= ST_SCAN;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign ready     = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

  `GWSP_ASSERT_ALWAYS(a_idle_after_rst, clk, $past(rst) |-> (state == ST_IDLE), "not idle after reset")
  `GWSP_ASSERT(a_nb_in_box, clk, rst, (state == ST_NB_CHK) |-> (nx <= box.x_last && ny <= box.y_last), "neighbour outside box")
  `GWSP_ASSERT(a_scan_wave, clk, rst, (state == ST_SCAN) |-> (wave >= WAVE_FIRST && wave <= WAVE_LIMIT), "wave label out of range")
  `GWSP_ASSERT(a_big_skips, clk, rst, (start && ready && box_in.too_large) |=> res_valid, "oversized box not reported at once")
  `GWSP_ASSERT(a_res_flags, clk, rst, res_valid |-> !(res.reachable && res.too_large), "reachable and too_large together")
  `GWSP_ASSERT(a_found_len, clk, rst, (res_valid && res.reachable) |-> (res.path_length != '0), "reached goal with zero length")

endmodule
`default_nettype wire

FILE: rtl/core/grid_wavefront_shortest_path.sv
`default_nettype none
// Lee wavefront router over one query of start, goal and one blocked cell. The
// padded bounding box of the three points is the search area; a query whose box
// is wider or taller than GRID_SIDE answers too_large without a search.
// Otherwise the whole label memory (one write and one read port) is cleared
// and the start, block and goal marks are written in turn. Each wave then
// sweeps the box once, and every cell of the previous wave stalls the sweep
// while its neighbours inside the box are read and, if free, labelled, since
// all label reads and writes share the single memory port pair. in_ready is
// high only while no query is in work; a finished result waits in an output
// register so the next query can already start.
module grid_wavefront_shortest_path import gwsp_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_IN_W-1:0] start_x,
  input  logic signed [COORD_IN_W-1:0] start_y,
  input  logic signed [COORD_IN_W-1:0] goal_x,
  input  logic signed [COORD_IN_W-1:0] goal_y,
  input  logic signed [COORD_IN_W-1:0] block_x,
  input  logic signed [COORD_IN_W-1:0] block_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output len_t                         path_length,
  output logic                         reachable,
  output logic                         too_large
);

  box_t    box;
  logic    eng_ready;
  logic    res_valid;
  logic    res_ready;
  result_t res;

  gwsp_box u_box (
    .start_x (start_x),
    .start_y (start_y),
    .goal_x  (goal_x),
    .goal_y  (goal_y),
    .block_x (block_x),
    .block_y (block_y),
    .box     (box)
  );

  gwsp_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (in_valid && in_ready),
    .box_in    (box),
    .ready     (eng_ready),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign in_ready  = eng_ready;
  assign res_ready = !out_valid || out_ready;

  // output register, one transaction deep
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid   <= 1'b1;
      path_length <= res.path_length;
      reachable   <= res.reachable;
      too_large   <= res.too_large;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: tb/sv/grid_wavefront_shortest_path_test.sv
module grid_wavefront_shortest_path_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gwsp_pkg::*;

  localparam int CYCLE_LIMIT = 8_000_000;
  localparam int RANDOM_QUERIES = 80;

  typedef struct {
    logic signed [COORD_IN_W-1:0] sx;
    logic signed [COORD_IN_W-1:0] sy;
    logic signed [COORD_IN_W-1:0] gx;
    logic signed [COORD_IN_W-1:0] gy;
    logic signed [COORD_IN_W-1:0] bx;
    logic signed [COORD_IN_W-1:0] by;
  } query_t;

  class route_scoreboard;
    result_t expected_routes[$];
    label_t labels[CELLS];
    int failures;
    int checked;
    int reached;
    int cut_off;
    int oversized;

    function int lo3(int a, int b, int c);
      int m;
      m = a;
      if (b < m) m = b;
      if (c < m) m = c;
      return m;
    endfunction

    function int hi3(int a, int b, int c);
      int m;
      m = a;
      if (b > m) m = b;
      if (c > m) m = c;
      return m;
    endfunction

    // lee flood from the start label, one sweep of the box per wave
    function result_t shortest_path(query_t q);
      result_t r;
      int sx, sy, gx, gy, bx, by;
      int x0, y0, wd, ht;
      int x, y, k, nx, ny, idx, len;
      label_t wave;
      label_t prev;
      bit grew;
      bit found;
      r = '0;
      sx = q.sx; sy = q.sy;
      gx = q.gx; gy = q.gy;
      bx = q.bx; by = q.by;
      x0 = lo3(sx, gx, bx) - 1;
      y0 = lo3(sy, gy, by) - 1;
      wd = hi3(sx, gx, bx) - x0 + 2;
      ht = hi3(sy, gy, by) - y0 + 2;
      if (wd > GRID_SIDE || ht > GRID_SIDE) begin
        r.too_large = 1'b1;
        return r;
      end
      foreach (labels[i]) labels[i] = LABEL_FREE;
      // goal overwrites block, block overwrites start
      labels[(sy - y0) * GRID_SIDE + (sx - x0)] = LABEL_START;
      labels[(by - y0) * GRID_SIDE + (bx - x0)] = MARK_BLOCK;
      labels[(gy - y0) * GRID_SIDE + (gx - x0)] = MARK_GOAL;
      wave = WAVE_FIRST;
      grew = 1'b1;
      found = 1'b0;
      len = 0;
      while (grew && !found) begin
        prev = label_t'(wave - 1);
        grew = 1'b0;
        for (y = 0; y < ht && !found; y++) begin
          for (x = 0; x < wd && !found; x++) begin
            if (labels[y * GRID_SIDE + x] != prev) continue;
            // neighbours in the order left, up, right, down
            for (k = 0; k < 4 && !found; k++) begin
              case (k)
                0: begin nx = x - 1; ny = y; end
                1: begin nx = x; ny = y - 1; end
                2: begin nx = x + 1; ny = y; end
                default: begin nx = x; ny = y + 1; end
              endcase
              if (nx < 0 || ny < 0 || nx >= wd || ny >= ht) continue;
              idx = ny * GRID_SIDE + nx;
              if (labels[idx] == MARK_GOAL) begin
                found = 1'b1;
              end else if (labels[idx] == LABEL_FREE) begin
                labels[idx] = wave;
                grew = 1'b1;
              end
            end
          end
        end
        if (found) len = int'(wave) - 1;
        else if (wave < WAVE_LIMIT) wave = label_t'(wave + 1);
        else grew = 1'b0;
      end
      if (found) begin
        r.path_length = (len > int'(LEN_MAX)) ? LEN_MAX : len_t'(len);
        r.reachable = 1'b1;
      end
      return r;
    endfunction

    function void note_query(query_t q);
      expected_routes.push_back(shortest_path(q));
    endfunction

    function int pending();
      return expected_routes.size();
    endfunction

    task report(string what);
      $display("MISMATCH at result %0d: %s", checked, what);
      failures++;
    endtask

    task check_result(len_t got_len, logic got_reach, logic got_big);
      result_t want;
      if (expected_routes.size() == 0) begin
        report("result with no query outstanding");
        return;
      end
      want = expected_routes.pop_front();
      if (got_len !== want.path_length)
        report($sformatf("path_length %0d, expected %0d", got_len, want.path_length));
      if (got_reach !== want.reachable)
        report($sformatf("reachable %b, expected %b", got_reach, want.reachable));
      if (got_big !== want.too_large)
        report($sformatf("too_large %b, expected %b", got_big, want.too_large));
      if (want.too_large) oversized++;
      else if (want.reachable) reached++;
      else cut_off++;
      checked++;
    endtask
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic signed [COORD_IN_W-1:0] start_x;
  logic signed [COORD_IN_W-1:0] start_y;
  logic signed [COORD_IN_W-1:0] goal_x;
  logic signed [COORD_IN_W-1:0] goal_y;
  logic signed [COORD_IN_W-1:0] block_x;
  logic signed [COORD_IN_W-1:0] block_y;
  logic out_valid;
  logic out_ready;
  len_t path_length;
  logic reachable;
  logic too_large;

  route_scoreboard book;
  bit eager;
  int out_stall;
  int queries_sent;
  int cycles;

  grid_wavefront_shortest_path dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .start_x(start_x),
    .start_y(start_y),
    .goal_x(goal_x),
    .goal_y(goal_y),
    .block_x(block_x),
    .block_y(block_y),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .path_length(path_length),
    .reachable(reachable),
    .too_large(too_large)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    if (eager) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 200);
  endfunction

  function automatic query_t make_query(int sx, int sy, int gx, int gy, int bx, int by);
    query_t q;
    q.sx = COORD_IN_W'(sx);
    q.sy = COORD_IN_W'(sy);
    q.gx = COORD_IN_W'(gx);
    q.gy = COORD_IN_W'(gy);
    q.bx = COORD_IN_W'(bx);
    q.by = COORD_IN_W'(by);
    return q;
  endfunction

  function automatic query_t random_query();
    query_t q;
    int roll, span_x, span_y, base_x, base_y, t;
    roll = $urandom_range(0, 99);
    if (roll < 25) begin
      // anywhere in the coordinate range, nearly always an oversized box
      q.sx = COORD_IN_W'($urandom);
      q.sy = COORD_IN_W'($urandom);
      q.gx = COORD_IN_W'($urandom);
      q.gy = COORD_IN_W'($urandom);
      q.bx = COORD_IN_W'($urandom);
      q.by = COORD_IN_W'($urandom);
      return q;
    end
    if (roll < 30) begin
      // long thin box around the size limit
      span_x = $urandom_range(55, 63);
      span_y = $urandom_range(0, 3);
      if ($urandom_range(0, 1) == 1) begin
        t = span_x; span_x = span_y; span_y = t;
      end
    end else begin
      span_x = $urandom_range(0, 7);
      span_y = $urandom_range(0, 7);
    end
    base_x = int'($urandom_range(0, 65535 - span_x)) - 32768;
    base_y = int'($urandom_range(0, 65535 - span_y)) - 32768;
    return make_query(base_x + $urandom_range(0, span_x), base_y + $urandom_range(0, span_y),
                      base_x + $urandom_range(0, span_x), base_y + $urandom_range(0, span_y),
                      base_x + $urandom_range(0, span_x), base_y + $urandom_range(0, span_y));
  endfunction

  task automatic send_query(query_t q);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    start_x = q.sx;
    start_y = q.sy;
    goal_x = q.gx;
    goal_y = q.gy;
    block_x = q.bx;
    block_y = q.by;
    do @(posedge clk); while (!in_ready);
    book.note_query(q);
    queries_sent++;
  endtask

  initial begin
    out_ready = 1'b0;
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (eager) begin
        out_ready = 1'b1;
      end else if (out_stall > 0) begin
        out_ready = 1'b0;
        out_stall--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) book.check_result(path_length, reachable, too_large);
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, book.pending());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    book = new();
    eager = 1'b0;
    queries_sent = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    start_x = '0;
    start_y = '0;
    goal_x = '0;
    goal_y = '0;
    block_x = '0;
    block_y = '0;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // coincident markers
    send_query(make_query(0, 0, 0, 0, 0, 0));
    send_query(make_query(5, 5, 5, 5, 7, 5));
    send_query(make_query(-3, 4, 2, 6, -3, 4));
    send_query(make_query(0, 0, 3, 2, 3, 2));
    // short paths, detour around the block
    send_query(make_query(10, 10, 11, 10, 10, 11));
    send_query(make_query(0, 0, 4, 0, 2, 0));
    send_query(make_query(0, 0, 0, 4, 0, 2));
    send_query(make_query(-1, -1, 1, 1, 0, 0));
    // coordinate extremes
    send_query(make_query(-32768, -32768, -32766, -32765, -32767, -32767));
    send_query(make_query(32767, 32767, 32765, 32764, 32766, 32766));
    send_query(make_query(-32768, 32767, -32765, 32765, -32767, 32766));
    // padded box exactly at the grid side, then one over
    send_query(make_query(100, 0, 161, 0, 130, 0));
    send_query(make_query(100, 0, 162, 0, 130, 1));
    send_query(make_query(0, -200, 0, -139, 0, -170));
    send_query(make_query(1, -200, 0, -138, 0, -170));
    // full grid box, short and medium distances
    send_query(make_query(0, 0, 1, 1, 61, 61));
    send_query(make_query(0, 0, 20, 10, 61, 61));
    // far apart in one axis, then in both
    send_query(make_query(-32768, 0, 32767, 0, 0, 0));
    send_query(make_query(0, 32767, 0, -32768, 1, 1));
    send_query(make_query(21845, -21846, 21845, -21846, -21846, 21845));

    for (int i = 0; i < RANDOM_QUERIES; i++) begin
      // some stretches run with no idling on either side
      if (i % 20 == 0) eager = ($urandom_range(0, 3) == 0);
      send_query(random_query());
    end
    @(negedge clk);
    in_valid = 1'b0;

    while (book.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d queries, checked %0d results", queries_sent, book.checked);
    $display("reachable %0d, cut off %0d, box too large %0d",
             book.reached, book.cut_off, book.oversized);
    if (book.failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/gwsp_pkg.sv
rtl/core/gwsp_box.sv
rtl/core/gwsp_engine.sv
rtl/core/grid_wavefront_shortest_path.sv
tb/sv/grid_wavefront_shortest_path_test.sv
